// ===== rtl/vsrt_pkg.sv =====
// Shared types, constants and functions for the vertex scale/rotate/translate core.
// Holds the quarter-wave sine table, built at elaboration, and the saturation helper.
// No dependencies.
package vsrt_pkg;

	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int PROD_W = 14 + IDX_W;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// coordinate and trig widths
	localparam int COORD_W = 32;
	localparam int TRIG_W = 18;

	typedef enum logic [2:0] {
		REG_SCALE    = 3'd0,
		REG_ANGLE_X  = 3'd1,
		REG_ANGLE_Y  = 3'd2,
		REG_ANGLE_Z  = 3'd3,
		REG_OFFSET_X = 3'd4,
		REG_OFFSET_Y = 3'd5,
		REG_OFFSET_Z = 3'd6
	} reg_idx_t;

	typedef logic [16:0] sine_rom_t [0:SINE_TABLE_DEPTH];

	typedef struct packed {
		logic signed [COORD_W-1:0] val;
		logic                      ovf;
	} sat_t;

	// sine and cosine pair for one axis
	typedef struct packed {
		logic signed [TRIG_W-1:0] s;
		logic signed [TRIG_W-1:0] c;
	} trig_t;

	// configuration state seen by the datapath
	typedef struct packed {
		logic signed [COORD_W-1:0] scale;
		trig_t                     rot_x;
		trig_t                     rot_y;
		trig_t                     rot_z;
		logic signed [COORD_W-1:0] off_x;
		logic signed [COORD_W-1:0] off_y;
		logic signed [COORD_W-1:0] off_z;
	} cfg_t;

	// Taylor series divisors (2k)(2k+1)
	localparam logic [63:0] SERIES_DIV [1:8] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
	};

	// sin of Q30 angle by truncated series, rounded to Q16 and clamped
	function automatic logic [16:0] series_sine(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] sum;
		x2 = (x * x) >> 30;
		term = x;
		sum = $signed(x);
		for (int k = 1; k <= 8; k++) begin
			term = (term * x2) >> 30;
			term = term / SERIES_DIV[k];
			if (k % 2 == 1) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		sum = (sum + 64'sd8192) >>> 14;
		if (sum > 64'sd65536) begin
			sum = 64'sd65536;
		end
		return sum[16:0];
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
			rom[i] = series_sine((HALF_PI_Q30 * 64'(i)) / 64'(SINE_TABLE_DEPTH));
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	// sine of a 16-bit turn fraction in signed Q2.16
	function automatic logic signed [TRIG_W-1:0] sine_of(input logic [15:0] a);
		logic [PROD_W-1:0] prod;
		logic [IDX_W-1:0] idx;
		logic [16:0] mag;
		prod = PROD_W'(a[13:0]) * PROD_W'(SINE_TABLE_DEPTH);
		idx = prod[PROD_W-1:14];
		if (a[14]) begin
			idx = IDX_W'(SINE_TABLE_DEPTH) - idx;
		end
		mag = SINE_ROM[idx];
		return a[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	endfunction

	// saturate a wide signed value to 32 bits
	function automatic sat_t sat32(input logic signed [63:0] v);
		sat_t r;
		if (v > 64'sd2147483647) begin
			r.val = 32'sh7fffffff;
			r.ovf = 1'b1;
		end else if (v < -64'sd2147483648) begin
			r.val = 32'sh80000000;
			r.ovf = 1'b1;
		end else begin
			r.val = v[31:0];
			r.ovf = 1'b0;
		end
		return r;
	endfunction

endpackage

// ===== rtl/vertex_scale_rotate_translate_core.sv =====
// Vertex model transform: scale, rotate about x, y, z, then translate.
// Throughput is one item per cycle while the output is not blocked.
// Stages: scale multiply, then one rotation per stage, then offset add into the
// output register. A blocked result holds each full stage behind it; bubbles close up.
// Reset clears all valid bits and loads the configuration reset values.
module vertex_scale_rotate_translate_core import vsrt_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [COORD_W-1:0] vin_x,
	input  logic signed [COORD_W-1:0] vin_y,
	input  logic signed [COORD_W-1:0] vin_z,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [COORD_W-1:0] vout_x,
	output logic signed [COORD_W-1:0] vout_y,
	output logic signed [COORD_W-1:0] vout_z,
	output logic                      overflow,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [2:0]                cfg_index,
	input  logic [COORD_W-1:0]        cfg_data
);

	cfg_t cfg;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;
	logic signed [63:0] px_s1, py_s1, pz_s1;
	logic signed [COORD_W-1:0] x_s2, y_s3, z_s4;
	logic ovf_s2, ovf_s3, ovf_s4;
	logic signed [COORD_W-1:0] x_s5, y_s5, z_s5;
	logic ovf_s5;
	sat_t sx, sy, sz;
	logic signed [COORD_W-1:0] rx_u, rx_v, ry_u, ry_v, rz_u, rz_v;
	logic rx_ovf, ry_ovf, rz_ovf;
	sat_t ox, oy, oz;

	assign cfg_ready = 1'b1;

	vsrt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid),
		.wr_idx  (cfg_index),
		.wr_data (cfg_data),
		.cfg     (cfg)
	);

	// advance a stage when it is empty or the next one moves
	assign en5 = !v_s5 || out_ready;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// stage 1: scale products
	always_ff @(posedge clk) begin
		if (en1) begin
			px_s1 <= 64'(vin_x) * 64'(cfg.scale);
			py_s1 <= 64'(vin_y) * 64'(cfg.scale);
			pz_s1 <= 64'(vin_z) * 64'(cfg.scale);
		end
	end

	always_comb begin
		sx = sat32(px_s1 >>> 16);
		sy = sat32(py_s1 >>> 16);
		sz = sat32(pz_s1 >>> 16);
	end

	// stage 2: rotate about x (y-z plane)
	vsrt_rotate u_rot_x (
		.clk (clk), .en (en2), .a (sy.val), .b (sz.val), .trig (cfg.rot_x),
		.u (rx_u), .v (rx_v), .ovf (rx_ovf)
	);

	always_ff @(posedge clk) begin
		if (en2) begin
			x_s2 <= sx.val;
			ovf_s2 <= sx.ovf | sy.ovf | sz.ovf;
		end
	end

	// stage 3: rotate about y (x-z plane)
	vsrt_rotate u_rot_y (
		.clk (clk), .en (en3), .a (x_s2), .b (rx_v), .trig (cfg.rot_y),
		.u (ry_u), .v (ry_v), .ovf (ry_ovf)
	);

	always_ff @(posedge clk) begin
		if (en3) begin
			y_s3 <= rx_u;
			ovf_s3 <= ovf_s2 | rx_ovf;
		end
	end

	// stage 4: rotate about z (x-y plane)
	vsrt_rotate u_rot_z (
		.clk (clk), .en (en4), .a (ry_u), .b (y_s3), .trig (cfg.rot_z),
		.u (rz_u), .v (rz_v), .ovf (rz_ovf)
	);

	always_ff @(posedge clk) begin
		if (en4) begin
			z_s4 <= ry_v;
			ovf_s4 <= ovf_s3 | ry_ovf;
		end
	end

	// stage 5: add offsets into the output register
	always_comb begin
		ox = sat32(64'(rz_u) + 64'(cfg.off_x));
		oy = sat32(64'(rz_v) + 64'(cfg.off_y));
		oz = sat32(64'(z_s4) + 64'(cfg.off_z));
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			x_s5 <= ox.val;
			y_s5 <= oy.val;
			z_s5 <= oz.val;
			ovf_s5 <= ovf_s4 | rz_ovf | ox.ovf | oy.ovf | oz.ovf;
		end
	end

	assign out_valid = v_s5;
	assign vout_x = x_s5;
	assign vout_y = y_s5;
	assign vout_z = z_s5;
	assign overflow = ovf_s5;

	// an accepted item lands in stage 1
	a_accept_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted item not captured in stage 1");

	// input stalls only when the whole pipe is full and blocked
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && !out_ready)
		else $error("input stalled with a bubble in the pipe");

	// a blocked result is not dropped
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !out_ready |=> v_s5)
		else $error("pending result lost");

endmodule

// ===== rtl/vsrt_cfg.sv =====
// Configuration register file with registered sine/cosine lookup per axis.
// Depends on vsrt_pkg.
module vsrt_cfg import vsrt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [2:0]            wr_idx,
	input  logic [COORD_W-1:0]    wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;
	logic [15:0] ang;
	logic signed [TRIG_W-1:0] sin_v;
	logic signed [TRIG_W-1:0] cos_v;

	// look up sine and cosine of the angle being written
	always_comb begin
		ang = wr_data[15:0];
		sin_v = sine_of(ang);
		cos_v = sine_of(ang + 16'd16384);
	end

	// hold registers; x axis keeps negated sine so all axes share one rotate form
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale <= 32'sd65536;
			cfg_q.rot_x <= '{s: '0, c: 18'sd65536};
			cfg_q.rot_y <= '{s: '0, c: 18'sd65536};
			cfg_q.rot_z <= '{s: '0, c: 18'sd65536};
			cfg_q.off_x <= '0;
			cfg_q.off_y <= '0;
			cfg_q.off_z <= '0;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_idx))
				REG_SCALE:    cfg_q.scale <= $signed(wr_data);
				REG_ANGLE_X:  cfg_q.rot_x <= '{s: -sin_v, c: cos_v};
				REG_ANGLE_Y:  cfg_q.rot_y <= '{s: sin_v, c: cos_v};
				REG_ANGLE_Z:  cfg_q.rot_z <= '{s: sin_v, c: cos_v};
				REG_OFFSET_X: cfg_q.off_x <= $signed(wr_data);
				REG_OFFSET_Y: cfg_q.off_y <= $signed(wr_data);
				REG_OFFSET_Z: cfg_q.off_z <= $signed(wr_data);
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/vsrt_rotate.sv =====
// One plane rotation: registered products, then sum, floor shift and saturate.
// Computes u = a*c - b*s and v = a*s + b*c in Q16.16. Depends on vsrt_pkg.
module vsrt_rotate import vsrt_pkg::*; (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [COORD_W-1:0] a,
	input  logic signed [COORD_W-1:0] b,
	input  trig_t                     trig,
	output logic signed [COORD_W-1:0] u,
	output logic signed [COORD_W-1:0] v,
	output logic                      ovf
);

	localparam int P_W = COORD_W + TRIG_W;

	logic signed [P_W-1:0] ac_q, bs_q, as_q, bc_q;
	logic signed [P_W:0] sum_u, sum_v;
	sat_t sat_u, sat_v;

	// capture the four partial products
	always_ff @(posedge clk) begin
		if (en) begin
			ac_q <= P_W'(a) * P_W'(trig.c);
			bs_q <= P_W'(b) * P_W'(trig.s);
			as_q <= P_W'(a) * P_W'(trig.s);
			bc_q <= P_W'(b) * P_W'(trig.c);
		end
	end

	// combine, floor shift, saturate
	always_comb begin
		sum_u = (P_W+1)'(ac_q) - (P_W+1)'(bs_q);
		sum_v = (P_W+1)'(as_q) + (P_W+1)'(bc_q);
		sat_u = sat32(64'(sum_u >>> 16));
		sat_v = sat32(64'(sum_v >>> 16));
	end

	assign u = sat_u.val;
	assign v = sat_v.val;
	assign ovf = sat_u.ovf | sat_v.ovf;

endmodule

// ===== tb/vsrt_checker.sv =====
// Checker for the vertex scale/rotate/translate core: tracks configuration writes,
// predicts each transformed vertex and compares it with the output channel.
// Depends on vsrt_pkg for widths and register indexes.
module vsrt_checker import vsrt_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic signed [COORD_W-1:0] vin_x,
	input  logic signed [COORD_W-1:0] vin_y,
	input  logic signed [COORD_W-1:0] vin_z,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic signed [COORD_W-1:0] vout_x,
	input  logic signed [COORD_W-1:0] vout_y,
	input  logic signed [COORD_W-1:0] vout_z,
	input  logic                      overflow,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [2:0]                cfg_index,
	input  logic [COORD_W-1:0]        cfg_data,
	output int                        errors,
	output int                        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic                      ovf;
	} vertex_result_t;

	longint quarter_wave [0:SINE_TABLE_DEPTH];
	vertex_result_t transformed_q [$];

	// local copy of the configuration registers
	longint scale_q16;
	logic [15:0] turn_x, turn_y, turn_z;
	longint shift_x, shift_y, shift_z;

	// build the quarter-wave table: Q30 Taylor series rounded to Q16
	initial begin
		bit [63:0] ang, sq, term;
		longint acc;
		for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
			ang = (64'd1686629713 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
			sq = (ang * ang) >> 30;
			term = ang;
			acc = longint'(ang);
			for (int k = 1; k <= 8; k++) begin
				term = (term * sq) >> 30;
				term = term / 64'((2 * k) * (2 * k + 1));
				acc = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
			end
			if (acc < 0) acc = 0;
			acc = (acc + 8192) >>> 14;
			if (acc > 65536) acc = 65536;
			quarter_wave[i] = acc;
		end
	end

	function automatic longint turn_sine(input logic [15:0] a);
		longint idx;
		idx = (longint'(a[13:0]) * SINE_TABLE_DEPTH) >>> 14;
		if (idx > SINE_TABLE_DEPTH) idx = SINE_TABLE_DEPTH;
		if (a[14]) idx = SINE_TABLE_DEPTH - idx;
		return a[15] ? -quarter_wave[idx] : quarter_wave[idx];
	endfunction

	function automatic longint clamp32(input longint v, inout logic ovf);
		if (v > 64'sd2147483647) begin
			ovf = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			ovf = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// (u*p + v*q) floored by 16 bits, then clamped
	function automatic longint rotate_term(input longint u, p, v, q, inout logic ovf);
		return clamp32((u * p + v * q) >>> 16, ovf);
	endfunction

	function automatic vertex_result_t model_transform(input longint px, py, pz);
		vertex_result_t r;
		logic ovf;
		longint x, y, z, nx, ny, nz, s, c;
		ovf = 1'b0;
		x = clamp32((px * scale_q16) >>> 16, ovf);
		y = clamp32((py * scale_q16) >>> 16, ovf);
		z = clamp32((pz * scale_q16) >>> 16, ovf);
		// rotate about x in the y-z plane
		s = turn_sine(turn_x);
		c = turn_sine(turn_x + 16'd16384);
		ny = rotate_term(y, c, z, s, ovf);
		nz = rotate_term(y, -s, z, c, ovf);
		y = ny;
		z = nz;
		// rotate about y in the x-z plane
		s = turn_sine(turn_y);
		c = turn_sine(turn_y + 16'd16384);
		nx = rotate_term(x, c, z, -s, ovf);
		nz = rotate_term(x, s, z, c, ovf);
		x = nx;
		z = nz;
		// rotate about z in the x-y plane
		s = turn_sine(turn_z);
		c = turn_sine(turn_z + 16'd16384);
		nx = rotate_term(x, c, y, -s, ovf);
		ny = rotate_term(x, s, y, c, ovf);
		x = nx;
		y = ny;
		// translate
		r.x = clamp32(x + shift_x, ovf);
		r.y = clamp32(y + shift_y, ovf);
		r.z = clamp32(z + shift_z, ovf);
		r.ovf = ovf;
		return r;
	endfunction

	// track config, queue predictions, compare results
	always @(posedge clk or negedge arst_n) begin
		vertex_result_t want;
		if (!arst_n) begin
			transformed_q.delete();
			scale_q16 = 65536;
			turn_x = '0;
			turn_y = '0;
			turn_z = '0;
			shift_x = 0;
			shift_y = 0;
			shift_z = 0;
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SCALE:    scale_q16 = longint'($signed(cfg_data));
					REG_ANGLE_X:  turn_x = cfg_data[15:0];
					REG_ANGLE_Y:  turn_y = cfg_data[15:0];
					REG_ANGLE_Z:  turn_z = cfg_data[15:0];
					REG_OFFSET_X: shift_x = longint'($signed(cfg_data));
					REG_OFFSET_Y: shift_y = longint'($signed(cfg_data));
					REG_OFFSET_Z: shift_z = longint'($signed(cfg_data));
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (transformed_q.size() == 0) begin
					$error("result item with no vertex outstanding");
					errors++;
				end else begin
					want = transformed_q.pop_front();
					if (vout_x !== want.x) begin
						$error("vout_x expected %0d got %0d", want.x, vout_x);
						errors++;
					end
					if (vout_y !== want.y) begin
						$error("vout_y expected %0d got %0d", want.y, vout_y);
						errors++;
					end
					if (vout_z !== want.z) begin
						$error("vout_z expected %0d got %0d", want.z, vout_z);
						errors++;
					end
					if (overflow !== want.ovf) begin
						$error("overflow expected %0b got %0b", want.ovf, overflow);
						errors++;
					end
				end
			end
			if (in_valid && in_ready) begin
				transformed_q.push_back(model_transform(longint'(vin_x),
					longint'(vin_y), longint'(vin_z)));
			end
			pending = transformed_q.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// Top of the vertex core testbench: clock, reset, vertex and config stimulus, verdict.
// Depends on vsrt_pkg, the core and vsrt_checker.
module tb;
	import vsrt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY_WAIT = 12;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [COORD_W-1:0] vin_x = '0, vin_y = '0, vin_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [COORD_W-1:0] vout_x, vout_y, vout_z;
	logic overflow;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [COORD_W-1:0] cfg_data = '0;
	int errors, pending;
	int vertices_sent = 0;
	bit steady = 1'b0;
	bit hold_off = 1'b0;

	vertex_scale_rotate_translate_core DUT (.*);

	vsrt_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stalls, none while steady, all while holding off
	always @(negedge clk) begin
		if (hold_off) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady || ($urandom_range(99) >= 36);
		end
	end

	// hold the output off once so the pipeline fills and stalls the input
	initial begin
		wait (vertices_sent >= 300);
		@(negedge clk);
		hold_off = 1'b1;
		repeat (200) @(negedge clk);
		hold_off = 1'b0;
	end

	initial begin
		#2ms;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic send_vertex(input logic [31:0] x, y, z);
		while (!steady && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		vin_x <= x;
		vin_y <= y;
		vin_z <= z;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		vertices_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drain the pipeline before touching config
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (LATENCY_WAIT) @(negedge clk);
	endtask

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(4))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			2: return $urandom_range(0, 1) ? 32'($urandom_range(0, 1 << 24))
				: -32'($urandom_range(0, 1 << 24));
			default: return $urandom_range(0, 1) ? 32'($urandom_range(0, 40 << 16))
				: -32'($urandom_range(0, 40 << 16));
		endcase
	endfunction

	function automatic logic [31:0] pick_angle();
		case ($urandom_range(3))
			0: return 32'($urandom_range(0, 3) * 16384);
			1: return 32'hffff;
			default: return 32'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [31:0] pick_scale();
		case ($urandom_range(5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'h0;
			3: return $urandom;
			default: return $urandom_range(0, 1) ? 32'($urandom_range(0, 4 << 16))
				: -32'($urandom_range(0, 4 << 16));
		endcase
	endfunction

	function automatic logic [31:0] pick_offset();
		case ($urandom_range(3))
			0: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			1: return $urandom;
			default: return $urandom_range(0, 1) ? 32'($urandom_range(0, 100 << 16))
				: -32'($urandom_range(0, 100 << 16));
		endcase
	endfunction

	task automatic directed_vertices();
		send_vertex(32'h0, 32'h0, 32'h0);
		send_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		send_vertex(32'h80000000, 32'h80000000, 32'h80000000);
		send_vertex(32'h80000000, 32'h7fffffff, 32'h1);
		send_vertex(32'h00010000, 32'hffff0000, 32'h00020000);
		send_vertex(32'hffffffff, 32'hffffffff, 32'hffffffff);
	endtask

	initial begin
		logic [31:0] angle_set [4];
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// identity config from reset
		directed_vertices();
		wait_idle();

		// extreme config: max scale, quarter-turn multiples, max/min/zero offsets; bad index ignored
		write_reg(REG_SCALE, 32'h7fffffff);
		write_reg(REG_ANGLE_X, 32'd16384);
		write_reg(REG_ANGLE_Y, 32'd32768);
		write_reg(REG_ANGLE_Z, 32'd49152);
		write_reg(REG_OFFSET_X, 32'h7fffffff);
		write_reg(REG_OFFSET_Y, 32'h80000000);
		write_reg(REG_OFFSET_Z, 32'h0);
		write_reg(3'd7, 32'hffffffff);
		directed_vertices();
		wait_idle();

		write_reg(REG_SCALE, 32'h80000000);
		write_reg(REG_ANGLE_X, 32'hffff);
		write_reg(REG_ANGLE_Y, 32'd8192);
		write_reg(REG_ANGLE_Z, 32'd1);
		write_reg(REG_OFFSET_X, 32'h80000000);
		write_reg(REG_OFFSET_Y, 32'h7fffffff);
		write_reg(REG_OFFSET_Z, 32'hfffe0000);
		directed_vertices();
		wait_idle();

		// random phases with random settings
		for (int phase = 0; phase < 11; phase++) begin
			write_reg(REG_SCALE, pick_scale());
			write_reg(REG_ANGLE_X, pick_angle());
			write_reg(REG_ANGLE_Y, pick_angle());
			write_reg(REG_ANGLE_Z, pick_angle());
			write_reg(REG_OFFSET_X, pick_offset());
			write_reg(REG_OFFSET_Y, pick_offset());
			write_reg(REG_OFFSET_Z, pick_offset());
			for (int n = 0; n < 100; n++) begin
				steady = (phase == 4);
				send_vertex(pick_coord(), pick_coord(), pick_coord());
			end
			steady = 1'b0;
			wait_idle();
		end

		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== vertex_scale_rotate_translate_core.f =====
rtl/vsrt_pkg.sv
rtl/vsrt_cfg.sv
rtl/vsrt_rotate.sv
rtl/vertex_scale_rotate_translate_core.sv
tb/vsrt_checker.sv
tb/tb.sv
